// File: rtl/core/sqt_pkg.sv
`default_nettype none
package sqt_pkg;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       end_of_query;
  } in_req_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [3:0]         operator_code;
    logic [7:0]         char_code;
    logic [15:0]        token_start;
    logic [15:0]        token_length;
    logic signed [31:0] int_value;
    logic [15:0]        param_index;
    logic [2:0]         error_code;
    logic               last_of_run;
  } out_res_t;

  localparam int RES_MAX = 3;

  typedef struct packed {
    logic [1:0]                count;
    out_res_t [RES_MAX-1:0]    res;
  } lex_batch_t;

  localparam logic [5:0] K_END   = 6'd0;
  localparam logic [5:0] K_ERR   = 6'd1;
  localparam logic [5:0] K_INT   = 6'd2;
  localparam logic [5:0] K_REAL  = 6'd3;
  localparam logic [5:0] K_STR   = 6'd4;
  localparam logic [5:0] K_QNAME = 6'd5;
  localparam logic [5:0] K_DATE  = 6'd6;
  localparam logic [5:0] K_BIND  = 6'd7;
  localparam logic [5:0] K_OPER  = 6'd8;
  localparam logic [5:0] K_STAR  = 6'd9;
  localparam logic [5:0] K_EQ    = 6'd10;
  localparam logic [5:0] K_CMP   = 6'd11;
  localparam logic [5:0] K_NEG   = 6'd12;
  localparam logic [5:0] K_PRM   = 6'd13;
  localparam logic [5:0] K_PRMNN = 6'd14;
  localparam logic [5:0] K_NAME  = 6'd15;
  localparam logic [5:0] K_CHAR  = 6'd16;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_PLUS   = 4'd0;
  localparam logic [3:0] OP_MINUS  = 4'd1;
  localparam logic [3:0] OP_MULT   = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_EQ     = 4'd4;
  localparam logic [3:0] OP_GE     = 4'd5;
  localparam logic [3:0] OP_GT     = 4'd6;
  localparam logic [3:0] OP_LE     = 4'd7;
  localparam logic [3:0] OP_NE     = 4'd8;
  localparam logic [3:0] OP_LT     = 4'd9;
  localparam logic [3:0] OP_CONCAT = 4'd10;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OPEN_STR = 3'd1;
  localparam logic [2:0] ERR_OPEN_QID = 3'd2;
  localparam logic [2:0] ERR_BAD_DATE = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  typedef struct packed {
    logic [63:0] txt;
    logic [3:0]  len;
    logic        fn;
    logic [5:0]  kind;
    logic [3:0]  op;
  } kw_entry_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
    logic [3:0] op;
  } kw_hit_t;

  localparam int KW_COUNT = 44;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{"all",      4'd3, 1'b0, 6'd17, OP_NONE},
    '{"and",      4'd3, 1'b0, 6'd18, OP_NONE},
    '{"asc",      4'd3, 1'b0, 6'd19, OP_NONE},
    '{"as",       4'd2, 1'b0, 6'd20, OP_NONE},
    '{"abs",      4'd3, 1'b1, 6'd21, OP_NONE},
    '{"avg",      4'd3, 1'b1, 6'd22, OP_NONE},
    '{"by",       4'd2, 1'b0, 6'd23, OP_NONE},
    '{"count",    4'd5, 1'b1, 6'd24, OP_NONE},
    '{"concat",   4'd6, 1'b0, K_OPER, OP_CONCAT},
    '{"desc",     4'd4, 1'b0, 6'd25, OP_NONE},
    '{"delete",   4'd6, 1'b0, 6'd26, OP_NONE},
    '{"distinct", 4'd8, 1'b0, 6'd27, OP_NONE},
    '{"date",     4'd4, 1'b1, 6'd28, OP_NONE},
    '{"from",     4'd4, 1'b0, 6'd29, OP_NONE},
    '{"group",    4'd5, 1'b0, 6'd30, OP_NONE},
    '{"isnull",   4'd6, 1'b1, 6'd31, OP_NONE},
    '{"is",       4'd2, 1'b0, 6'd32, OP_NONE},
    '{"into",     4'd4, 1'b0, 6'd33, OP_NONE},
    '{"in",       4'd2, 1'b0, 6'd34, OP_NONE},
    '{"insert",   4'd6, 1'b0, 6'd35, OP_NONE},
    '{"join",     4'd4, 1'b0, 6'd36, OP_NONE},
    '{"left",     4'd4, 1'b0, 6'd37, OP_NONE},
    '{"lock",     4'd4, 1'b0, 6'd38, OP_NONE},
    '{"like",     4'd4, 1'b0, 6'd39, OP_NONE},
    '{"limit",    4'd5, 1'b0, 6'd40, OP_NONE},
    '{"max",      4'd3, 1'b1, 6'd41, OP_NONE},
    '{"min",      4'd3, 1'b1, 6'd42, OP_NONE},
    '{"not",      4'd3, 1'b0, K_NEG, OP_NONE},
    '{"null",     4'd4, 1'b0, 6'd43, OP_NONE},
    '{"or",       4'd2, 1'b0, 6'd44, OP_NONE},
    '{"order",    4'd5, 1'b0, 6'd45, OP_NONE},
    '{"outer",    4'd5, 1'b0, 6'd46, OP_NONE},
    '{"power",    4'd5, 1'b1, 6'd47, OP_NONE},
    '{"round",    4'd5, 1'b1, 6'd48, OP_NONE},
    '{"right",    4'd5, 1'b1, 6'd49, OP_NONE},
    '{"set",      4'd3, 1'b0, 6'd50, OP_NONE},
    '{"select",   4'd6, 1'b0, 6'd51, OP_NONE},
    '{"substr",   4'd6, 1'b1, 6'd52, OP_NONE},
    '{"sum",      4'd3, 1'b1, 6'd53, OP_NONE},
    '{"trim",     4'd4, 1'b1, 6'd54, OP_NONE},
    '{"update",   4'd6, 1'b0, 6'd55, OP_NONE},
    '{"union",    4'd5, 1'b0, 6'd56, OP_NONE},
    '{"values",   4'd6, 1'b0, 6'd57, OP_NONE},
    '{"where",    4'd5, 1'b0, 6'd58, OP_NONE}
  };

  // word buffer holds byte k at bits 8k; table text is right-aligned, last char in low byte
  function automatic kw_hit_t kw_lookup(input logic [63:0] wb, input logic [3:0] wc,
                                        input logic fn);
    kw_hit_t    r;
    logic       match;
    logic [7:0] expb;
    int         p;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      match = (KW_TABLE[i].fn == fn) && (KW_TABLE[i].len == wc);
      for (int k = 0; k < 8; k++) begin
        p = int'(KW_TABLE[i].len) - 1 - k;
        expb = (p >= 0) ? KW_TABLE[i].txt[8*p +: 8] : 8'h00;
        if (wb[8*k +: 8] != expb) match = 1'b0;
      end
      if (match) begin
        r.hit  = 1'b1;
        r.kind = KW_TABLE[i].kind;
        r.op   = KW_TABLE[i].op;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sqt_lexer.sv
`default_nettype none
module sqt_lexer #(
  parameter int MAX_QUERY_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire sqt_pkg::in_req_t   req,
  output sqt_pkg::lex_batch_t     batch
);

  localparam int PW = $clog2(MAX_QUERY_BYTES);
  localparam logic [PW:0] MQ = (PW+1)'(MAX_QUERY_BYTES);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_QUERY_BYTES - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WORD, PH_INT, PH_FRAC, PH_EXP, PH_EXPSIGN, PH_EXPDIG,
    PH_STR, PH_ESC, PH_SKIP, PH_QID, PH_DATE, PH_HALT
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt, st_r, st_nxt, pos_inc;
  logic [63:0]   wb_r, wb_nxt;
  logic [3:0]    wc_r, wc_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic [7:0]    lb_r, lb_nxt;
  logic          lv_r, lv_nxt;

  logic [7:0]    b, fold;
  logic          eoq, is_dig, is_alpha, is_sp, is_wchar, idle_go, real_end;
  logic [31:0]   dv;
  logic [35:0]   mac;
  logic [15:0]   st16, pos16, sf16;
  logic [1:0]    k;
  sqt_pkg::kw_hit_t kwf;
  logic [3:0]    cand_v;
  sqt_pkg::out_res_t cand [4];

  function automatic logic [15:0] lo16(input logic [PW-1:0] x);
    logic [PW+15:0] t;
    t = {16'h0, x};
    return t[15:0];
  endfunction

  function automatic logic [PW-1:0] span(input logic [PW-1:0] s, input logic [PW-1:0] e);
    logic [PW:0] d;
    if (e >= s) d = {1'b0, e} - {1'b0, s};
    else d = {1'b0, e} + MQ - {1'b0, s};
    return d[PW-1:0];
  endfunction

  function automatic sqt_pkg::out_res_t mk(input logic [5:0] kind, input logic [3:0] op,
                                           input logic [7:0] ch, input logic [15:0] start,
                                           input logic [15:0] len, input logic [31:0] ival,
                                           input logic [15:0] pidx, input logic [2:0] err);
    sqt_pkg::out_res_t r;
    r.token_kind    = kind;
    r.operator_code = op;
    r.char_code     = ch;
    r.token_start   = start;
    r.token_length  = len;
    r.int_value     = ival;
    r.param_index   = pidx;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic sqt_pkg::out_res_t flush_res(input logic [7:0] c, input logic [15:0] s,
                                                  input logic [15:0] pc);
    sqt_pkg::out_res_t r;
    case (c)
      sqt_pkg::CH_MINUS: r = mk(sqt_pkg::K_OPER, sqt_pkg::OP_MINUS, 8'h0, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
      sqt_pkg::CH_EQ:    r = mk(sqt_pkg::K_EQ, sqt_pkg::OP_EQ, 8'h0, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
      sqt_pkg::CH_GT:    r = mk(sqt_pkg::K_CMP, sqt_pkg::OP_GT, 8'h0, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
      sqt_pkg::CH_LT:    r = mk(sqt_pkg::K_CMP, sqt_pkg::OP_LT, 8'h0, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
      sqt_pkg::CH_BANG:  r = mk(sqt_pkg::K_NEG, sqt_pkg::OP_NONE, 8'h0, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
      sqt_pkg::CH_QUEST: r = mk(sqt_pkg::K_PRM, sqt_pkg::OP_NONE, 8'h0, s, 16'd1, 32'h0,
                                pc, sqt_pkg::ERR_NONE);
      default:           r = mk(sqt_pkg::K_CHAR, sqt_pkg::OP_NONE, c, s, 16'd1, 32'h0,
                                16'h0, sqt_pkg::ERR_NONE);
    endcase
    return r;
  endfunction

  function automatic sqt_pkg::out_res_t word_res(input logic [63:0] w, input logic [3:0] n,
                                                 input logic [15:0] s, input logic [15:0] len);
    sqt_pkg::kw_hit_t h;
    h = sqt_pkg::kw_lookup(w, n, 1'b0);
    if (h.hit) return mk(h.kind, h.op, 8'h0, s, len, 32'h0, 16'h0, sqt_pkg::ERR_NONE);
    return mk(sqt_pkg::K_NAME, sqt_pkg::OP_NONE, 8'h0, s, len, 32'h0, 16'h0,
              sqt_pkg::ERR_NONE);
  endfunction

  function automatic sqt_pkg::out_res_t int_res(input logic [31:0] a, input logic ng,
                                                input logic [15:0] s, input logic [15:0] len);
    logic [31:0] lim, mag;
    logic [2:0]  err;
    lim = ng ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = a;
    err = sqt_pkg::ERR_NONE;
    if (a > lim) begin
      mag = lim;
      err = sqt_pkg::ERR_OVERFLOW;
    end
    return mk(sqt_pkg::K_INT, sqt_pkg::OP_NONE, 8'h0, s, len, ng ? (32'h0 - mag) : mag,
              16'h0, err);
  endfunction

  assign b        = req.query_byte;
  assign eoq      = req.end_of_query;
  assign is_dig   = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  assign is_sp    = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  assign is_wchar = is_alpha || is_dig || (b == sqt_pkg::CH_UNDER);
  assign fold     = ((b >= 8'h41) && (b <= 8'h5A)) ? (b | 8'h20) : b;
  assign dv       = {24'h0, b - 8'h30};
  assign mac      = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {28'h0, b - 8'h30};
  assign pos_inc  = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
  assign st16     = lo16(st_r);
  assign pos16    = lo16(pos_r);
  assign kwf      = sqt_pkg::kw_lookup(wb_r, wc_r, 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_inc;
    st_nxt    = st_r;
    wb_nxt    = wb_r;
    wc_nxt    = wc_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    pc_nxt    = pc_r;
    lb_nxt    = lb_r;
    lv_nxt    = lv_r;
    cand_v    = '0;
    for (int i = 0; i < 4; i++) cand[i] = '0;
    idle_go   = 1'b0;
    real_end  = 1'b0;
    sf16      = '0;

    if (lv_r) begin
      lv_nxt = 1'b0;
      if (lb_r == sqt_pkg::CH_MINUS && is_dig) begin
        phase_nxt = PH_INT;
        neg_nxt   = 1'b1;
        acc_nxt   = dv;
      end else if (lb_r == sqt_pkg::CH_DOT && is_dig) begin
        phase_nxt = PH_FRAC;
      end else if (lb_r == sqt_pkg::CH_EQ && b == sqt_pkg::CH_EQ) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_EQ, sqt_pkg::OP_EQ, 8'h0, st16, 16'd2, 32'h0, 16'h0,
                     sqt_pkg::ERR_NONE);
      end else if (lb_r == sqt_pkg::CH_GT && b == sqt_pkg::CH_EQ) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_CMP, sqt_pkg::OP_GE, 8'h0, st16, 16'd2, 32'h0, 16'h0,
                     sqt_pkg::ERR_NONE);
      end else if (lb_r == sqt_pkg::CH_LT && b == sqt_pkg::CH_EQ) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_CMP, sqt_pkg::OP_LE, 8'h0, st16, 16'd2, 32'h0, 16'h0,
                     sqt_pkg::ERR_NONE);
      end else if ((lb_r == sqt_pkg::CH_LT && b == sqt_pkg::CH_GT) ||
                   (lb_r == sqt_pkg::CH_BANG && b == sqt_pkg::CH_EQ)) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_CMP, sqt_pkg::OP_NE, 8'h0, st16, 16'd2, 32'h0, 16'h0,
                     sqt_pkg::ERR_NONE);
      end else if (lb_r == sqt_pkg::CH_QUEST && b == sqt_pkg::CH_QUEST) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_PRMNN, sqt_pkg::OP_NONE, 8'h0, st16, 16'd2, 32'h0, pc_r,
                     sqt_pkg::ERR_NONE);
        pc_nxt = pc_r + 16'd1;
      end else begin
        cand_v[0] = 1'b1;
        cand[0] = flush_res(lb_r, st16, pc_r);
        if (lb_r == sqt_pkg::CH_QUEST) pc_nxt = pc_r + 16'd1;
        idle_go = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_WORD: begin
          if (is_wchar) begin
            if (wc_r < 4'd8) wb_nxt[{wc_r[2:0], 3'b000} +: 8] = fold;
            if (wc_r < 4'd15) wc_nxt = wc_r + 4'd1;
          end else if (b == sqt_pkg::CH_LPAR && !eoq && kwf.hit) begin
            cand_v[0] = 1'b1;
            cand[0] = mk(kwf.kind, sqt_pkg::OP_NONE, 8'h0, st16,
                         lo16(span(st_r, pos_r)) + 16'd1, 32'h0, 16'h0, sqt_pkg::ERR_NONE);
            phase_nxt = PH_IDLE;
          end else begin
            cand_v[0] = 1'b1;
            cand[0] = word_res(wb_r, wc_r, st16, lo16(span(st_r, pos_r)));
            phase_nxt = PH_IDLE;
            idle_go = 1'b1;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            acc_nxt = (|mac[35:32]) ? 32'hFFFF_FFFF : mac[31:0];
          end else if (b == sqt_pkg::CH_DOT) begin
            phase_nxt = PH_FRAC;
          end else if (b == sqt_pkg::CH_LOW_E || b == sqt_pkg::CH_UP_E) begin
            phase_nxt = PH_EXP;
          end else begin
            cand_v[0] = 1'b1;
            cand[0] = int_res(acc_r, neg_r, st16, lo16(span(st_r, pos_r)));
            phase_nxt = PH_IDLE;
            idle_go = 1'b1;
          end
        end
        PH_FRAC: begin
          if (b == sqt_pkg::CH_LOW_E || b == sqt_pkg::CH_UP_E) phase_nxt = PH_EXP;
          else if (!is_dig) real_end = 1'b1;
        end
        PH_EXP: begin
          if (b == sqt_pkg::CH_PLUS || b == sqt_pkg::CH_MINUS) phase_nxt = PH_EXPSIGN;
          else if (is_dig) phase_nxt = PH_EXPDIG;
          else real_end = 1'b1;
        end
        PH_EXPSIGN, PH_EXPDIG: begin
          if (is_dig) phase_nxt = PH_EXPDIG;
          else real_end = 1'b1;
        end
        PH_STR: begin
          if (b == sqt_pkg::CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else if (b == sqt_pkg::CH_SQUOTE) begin
            cand_v[0] = 1'b1;
            cand[0] = mk(sqt_pkg::K_STR, sqt_pkg::OP_NONE, 8'h0, st16 + 16'd1,
                         lo16(span(st_r, pos_r)) - 16'd1, 32'h0, 16'h0, sqt_pkg::ERR_NONE);
            phase_nxt = PH_IDLE;
          end
        end
        PH_ESC: phase_nxt = (b == sqt_pkg::CH_SQUOTE) ? PH_SKIP : PH_STR;
        PH_SKIP: phase_nxt = PH_STR;
        PH_QID: begin
          if (b == sqt_pkg::CH_DQUOTE) begin
            cand_v[0] = 1'b1;
            cand[0] = mk(sqt_pkg::K_QNAME, sqt_pkg::OP_NONE, 8'h0, st16 + 16'd1,
                         lo16(span(st_r, pos_r)) - 16'd1, 32'h0, 16'h0, sqt_pkg::ERR_NONE);
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATE: begin
          wc_nxt = wc_r + 4'd1;
          if (wc_r >= 4'd8) begin
            cand_v[0] = 1'b1;
            if (b == sqt_pkg::CH_RBRACK) begin
              cand[0] = mk(sqt_pkg::K_DATE, sqt_pkg::OP_NONE, 8'h0, st16 + 16'd1, 16'd8,
                           32'h0, 16'h0, sqt_pkg::ERR_NONE);
              phase_nxt = PH_IDLE;
            end else begin
              cand[0] = mk(sqt_pkg::K_ERR, sqt_pkg::OP_NONE, 8'h0, st16, 16'd0, 32'h0,
                           16'h0, sqt_pkg::ERR_BAD_DATE);
              phase_nxt = PH_HALT;
            end
          end
        end
        PH_HALT: ;
        default: idle_go = 1'b1;
      endcase
      if (real_end) begin
        cand_v[0] = 1'b1;
        cand[0] = mk(sqt_pkg::K_REAL, sqt_pkg::OP_NONE, 8'h0, st16, lo16(span(st_r, pos_r)),
                     32'h0, 16'h0, sqt_pkg::ERR_NONE);
        phase_nxt = PH_IDLE;
        idle_go = 1'b1;
      end
    end

    if (idle_go) begin
      st_nxt = pos_r;
      if (is_sp) begin
        st_nxt = pos_r;
      end else if (is_dig) begin
        phase_nxt = PH_INT;
        neg_nxt   = 1'b0;
        acc_nxt   = dv;
      end else if (is_alpha || b == sqt_pkg::CH_UNDER) begin
        phase_nxt = PH_WORD;
        wb_nxt    = {56'h0, fold};
        wc_nxt    = 4'd1;
      end else begin
        case (b)
          sqt_pkg::CH_MINUS, sqt_pkg::CH_DOT, sqt_pkg::CH_EQ, sqt_pkg::CH_GT, sqt_pkg::CH_LT,
          sqt_pkg::CH_BANG, sqt_pkg::CH_QUEST: begin
            lb_nxt = b;
            lv_nxt = 1'b1;
          end
          sqt_pkg::CH_SQUOTE: phase_nxt = PH_STR;
          sqt_pkg::CH_DQUOTE: phase_nxt = PH_QID;
          sqt_pkg::CH_LBRACK: begin
            phase_nxt = PH_DATE;
            wc_nxt    = 4'd0;
          end
          sqt_pkg::CH_COLON: begin
            cand_v[1] = 1'b1;
            cand[1] = mk(sqt_pkg::K_BIND, sqt_pkg::OP_NONE, 8'h0, pos16, 16'd1, 32'h0, 16'h0,
                         sqt_pkg::ERR_NONE);
          end
          sqt_pkg::CH_PLUS: begin
            cand_v[1] = 1'b1;
            cand[1] = mk(sqt_pkg::K_OPER, sqt_pkg::OP_PLUS, 8'h0, pos16, 16'd1, 32'h0, 16'h0,
                         sqt_pkg::ERR_NONE);
          end
          sqt_pkg::CH_STAR: begin
            cand_v[1] = 1'b1;
            cand[1] = mk(sqt_pkg::K_STAR, sqt_pkg::OP_MULT, 8'h0, pos16, 16'd1, 32'h0, 16'h0,
                         sqt_pkg::ERR_NONE);
          end
          sqt_pkg::CH_SLASH: begin
            cand_v[1] = 1'b1;
            cand[1] = mk(sqt_pkg::K_OPER, sqt_pkg::OP_DIV, 8'h0, pos16, 16'd1, 32'h0, 16'h0,
                         sqt_pkg::ERR_NONE);
          end
          default: begin
            cand_v[1] = 1'b1;
            cand[1] = mk(sqt_pkg::K_CHAR, sqt_pkg::OP_NONE, b, pos16, 16'd1, 32'h0, 16'h0,
                         sqt_pkg::ERR_NONE);
          end
        endcase
      end
    end

    // end of query: flush pending token, then the end token
    if (eoq) begin
      sf16 = lo16(st_nxt);
      if (lv_nxt) begin
        cand_v[2] = 1'b1;
        cand[2] = flush_res(lb_nxt, sf16, pc_nxt);
      end else begin
        case (phase_nxt)
          PH_WORD: begin
            cand_v[2] = 1'b1;
            cand[2] = word_res(wb_nxt, wc_nxt, sf16, lo16(span(st_nxt, pos_inc)));
          end
          PH_INT: begin
            cand_v[2] = 1'b1;
            cand[2] = int_res(acc_nxt, neg_nxt, sf16, lo16(span(st_nxt, pos_inc)));
          end
          PH_FRAC, PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
            cand_v[2] = 1'b1;
            cand[2] = mk(sqt_pkg::K_REAL, sqt_pkg::OP_NONE, 8'h0, sf16,
                         lo16(span(st_nxt, pos_inc)), 32'h0, 16'h0, sqt_pkg::ERR_NONE);
          end
          PH_STR, PH_ESC, PH_SKIP: begin
            cand_v[2] = 1'b1;
            cand[2] = mk(sqt_pkg::K_ERR, sqt_pkg::OP_NONE, 8'h0, sf16, 16'd0, 32'h0, 16'h0,
                         sqt_pkg::ERR_OPEN_STR);
          end
          PH_QID: begin
            cand_v[2] = 1'b1;
            cand[2] = mk(sqt_pkg::K_ERR, sqt_pkg::OP_NONE, 8'h0, sf16, 16'd0, 32'h0, 16'h0,
                         sqt_pkg::ERR_OPEN_QID);
          end
          PH_DATE: begin
            cand_v[2] = 1'b1;
            cand[2] = mk(sqt_pkg::K_ERR, sqt_pkg::OP_NONE, 8'h0, sf16, 16'd0, 32'h0, 16'h0,
                         sqt_pkg::ERR_BAD_DATE);
          end
          default: ;
        endcase
      end
      cand_v[3] = 1'b1;
      cand[3] = mk(sqt_pkg::K_END, sqt_pkg::OP_NONE, 8'h0, lo16(pos_inc), 16'd0, 32'h0,
                   16'h0, sqt_pkg::ERR_NONE);
      phase_nxt = PH_IDLE;
      pos_nxt   = '0;
      st_nxt    = '0;
      wb_nxt    = '0;
      wc_nxt    = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      pc_nxt    = '0;
      lb_nxt    = '0;
      lv_nxt    = 1'b0;
    end
  end

  // pack the candidates in order; at most three are ever set
  always_comb begin
    batch = '0;
    k = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        batch.res[k] = cand[i];
        k = k + 2'd1;
      end
    end
    if (k != 2'd0) batch.res[k - 2'd1].last_of_run = 1'b1;
    batch.count = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      st_r    <= '0;
      wb_r    <= '0;
      wc_r    <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      pc_r    <= '0;
      lb_r    <= '0;
      lv_r    <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      st_r    <= st_nxt;
      wb_r    <= wb_nxt;
      wc_r    <= wc_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      pc_r    <= pc_nxt;
      lb_r    <= lb_nxt;
      lv_r    <= lv_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sqt_res_fifo.sv
`default_nettype none
module sqt_res_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sqt_pkg::lex_batch_t  batch,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sqt_pkg::out_res_t         out_data
);

  localparam int DEPTH = 8;
  localparam int AW = $clog2(DEPTH);

  sqt_pkg::out_res_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push    = push ? batch.count : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= (AW+1)'(DEPTH - sqt_pkg::RES_MAX));
  assign out_data  = mem_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + (AW+1)'(n_push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(n_push);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sqt_pkg::RES_MAX; i++) begin
      if (2'(i) < n_push) mem_r[wr_ptr_r + AW'(i)] <= batch.res[i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sql_query_tokenizer.sv
// Path: each byte is registered at the input, lexed and written into the result queue.
// Throughput: one byte per cycle while the 8-entry result queue has room for three tokens;
// a byte yields up to three tokens, drained one per cycle on the output while out_stall is low.
// Reset (synchronous, rst_n low): lexer idle, offsets and parameter count zero, queue empty.
`default_nettype none
module sql_query_tokenizer #(
  parameter int MAX_QUERY_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sqt_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sqt_pkg::out_res_t       out_data
);

  logic                in_v_r;
  sqt_pkg::in_req_t    in_data_r;
  logic                room, adv, accept;
  sqt_pkg::lex_batch_t batch;

  assign adv      = in_v_r && room;
  assign in_stall = in_v_r && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_data_r <= in_data;
  end

  sqt_lexer #(.MAX_QUERY_BYTES(MAX_QUERY_BYTES)) u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (in_data_r),
    .batch (batch)
  );

  sqt_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .batch     (batch),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: bench/sqt_token_checker.sv
`timescale 1ns / 100ps
module sqt_token_checker
  import sqt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire in_req_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire out_res_t out_data,
  output int            mismatch_count,
  output int            tokens_waiting
);

  typedef enum logic [3:0] {
    LX_IDLE, LX_WORD, LX_INT, LX_FRAC, LX_EXP, LX_EXPSIGN, LX_EXPDIG,
    LX_STR, LX_ESC, LX_SKIP, LX_QID, LX_DATE, LX_HALT
  } lex_phase_e;

  lex_phase_e  phase;
  logic [15:0] byte_pos, tok_start, param_cnt;
  logic [63:0] word_buf;
  logic [3:0]  word_len;
  logic [31:0] int_mag;
  logic        int_neg;
  logic [7:0]  held_byte;
  logic        held_valid;
  out_res_t    run_tokens[$];
  out_res_t    tokens_due[$];

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic void put(logic [5:0] kind, logic [3:0] op, logic [7:0] ch,
                              logic [15:0] st, logic [15:0] len, logic [31:0] ival,
                              logic [15:0] prm, logic [2:0] err);
    out_res_t r;
    r.token_kind    = kind;
    r.operator_code = op;
    r.char_code     = ch;
    r.token_start   = st;
    r.token_length  = len;
    r.int_value     = ival;
    r.param_index   = prm;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    if (run_tokens.size() < RES_MAX) run_tokens.push_back(r);
  endfunction

  function automatic void put_tok(logic [5:0] kind, logic [3:0] op, logic [15:0] len);
    put(kind, op, 8'd0, tok_start, len, 32'd0, 16'd0, ERR_NONE);
  endfunction

  function automatic void put_param(logic [5:0] kind, logic [15:0] len);
    put(kind, OP_NONE, 8'd0, tok_start, len, 32'd0, param_cnt, ERR_NONE);
    param_cnt++;
  endfunction

  function automatic bit kw_match(bit fn, output logic [5:0] kind, output logic [3:0] op);
    bit hit;
    kind = '0;
    op   = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (KW_TABLE[i].fn == fn && KW_TABLE[i].len == word_len) begin
        hit = 1'b1;
        for (int k = 0; k < int'(KW_TABLE[i].len); k++)
          if (word_buf[8*k +: 8] != KW_TABLE[i].txt[8*(int'(KW_TABLE[i].len)-1-k) +: 8])
            hit = 1'b0;
        if (hit) begin
          kind = KW_TABLE[i].kind;
          op   = KW_TABLE[i].op;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void word_add(logic [7:0] b);
    logic [7:0] f;
    f = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    if (word_len < 8) word_buf[8*word_len +: 8] = f;
    if (word_len < 15) word_len++;
  endfunction

  function automatic void word_out(logic [15:0] end_pos);
    logic [5:0] kind;
    logic [3:0] op;
    if (kw_match(1'b0, kind, op)) put_tok(kind, op, end_pos - tok_start);
    else put_tok(K_NAME, OP_NONE, end_pos - tok_start);
  endfunction

  function automatic void int_out(logic [15:0] end_pos);
    logic [31:0] lim, mag;
    logic [2:0]  err;
    lim = int_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = int_mag;
    err = ERR_NONE;
    if (mag > lim) begin
      mag = lim;
      err = ERR_OVERFLOW;
    end
    put(K_INT, OP_NONE, 8'd0, tok_start, end_pos - tok_start,
        int_neg ? -mag : mag, 16'd0, err);
  endfunction

  function automatic void held_flush();
    held_valid = 1'b0;
    case (held_byte)
      CH_MINUS: put_tok(K_OPER, OP_MINUS, 16'd1);
      CH_DOT:   put(K_CHAR, OP_NONE, CH_DOT, tok_start, 16'd1, 32'd0, 16'd0, ERR_NONE);
      CH_EQ:    put_tok(K_EQ, OP_EQ, 16'd1);
      CH_GT:    put_tok(K_CMP, OP_GT, 16'd1);
      CH_LT:    put_tok(K_CMP, OP_LT, 16'd1);
      CH_BANG:  put_tok(K_NEG, OP_NONE, 16'd1);
      CH_QUEST: put_param(K_PRM, 16'd1);
      default: ;
    endcase
  endfunction

  function automatic void scan_idle(logic [7:0] b, logic [15:0] p);
    tok_start = p;
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
    if (is_digit(b)) begin
      phase   = LX_INT;
      int_neg = 1'b0;
      int_mag = 32'(b - "0");
      return;
    end
    if (is_alpha(b) || b == CH_UNDER) begin
      phase    = LX_WORD;
      word_buf = '0;
      word_len = '0;
      word_add(b);
      return;
    end
    case (b)
      CH_MINUS, CH_DOT, CH_EQ, CH_GT, CH_LT, CH_BANG, CH_QUEST: begin
        held_byte  = b;
        held_valid = 1'b1;
      end
      CH_SQUOTE: phase = LX_STR;
      CH_DQUOTE: phase = LX_QID;
      CH_LBRACK: begin
        phase    = LX_DATE;
        word_len = '0;
      end
      CH_COLON: put_tok(K_BIND, OP_NONE, 16'd1);
      CH_PLUS:  put_tok(K_OPER, OP_PLUS, 16'd1);
      CH_STAR:  put_tok(K_STAR, OP_MULT, 16'd1);
      CH_SLASH: put_tok(K_OPER, OP_DIV, 16'd1);
      default:  put(K_CHAR, OP_NONE, b, p, 16'd1, 32'd0, 16'd0, ERR_NONE);
    endcase
  endfunction

  // returns 0 when the byte closed a pending token and has to be scanned again
  function automatic bit scan(logic [7:0] b, logic [15:0] p, bit eoq);
    logic [15:0] st;
    logic [7:0]  c;
    logic [63:0] t;
    logic [5:0]  kind;
    logic [3:0]  op;
    st = tok_start;
    if (held_valid) begin
      c = held_byte;
      held_valid = 1'b0;
      if (c == CH_MINUS && is_digit(b)) begin
        phase   = LX_INT;
        int_neg = 1'b1;
        int_mag = 32'(b - "0");
        return 1'b1;
      end
      if (c == CH_DOT && is_digit(b)) begin
        phase = LX_FRAC;
        return 1'b1;
      end
      if (c == CH_EQ && b == CH_EQ) begin put_tok(K_EQ, OP_EQ, 16'd2); return 1'b1; end
      if (c == CH_GT && b == CH_EQ) begin put_tok(K_CMP, OP_GE, 16'd2); return 1'b1; end
      if (c == CH_LT && b == CH_EQ) begin put_tok(K_CMP, OP_LE, 16'd2); return 1'b1; end
      if (c == CH_LT && b == CH_GT) begin put_tok(K_CMP, OP_NE, 16'd2); return 1'b1; end
      if (c == CH_BANG && b == CH_EQ) begin put_tok(K_CMP, OP_NE, 16'd2); return 1'b1; end
      if (c == CH_QUEST && b == CH_QUEST) begin put_param(K_PRMNN, 16'd2); return 1'b1; end
      held_valid = 1'b1;
      held_flush();
      return 1'b0;
    end
    case (phase)
      LX_WORD: begin
        if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
          word_add(b);
          return 1'b1;
        end
        if (b == CH_LPAR && !eoq && kw_match(1'b1, kind, op)) begin
          put_tok(kind, OP_NONE, (p - st) + 16'd1);
          phase = LX_IDLE;
          return 1'b1;
        end
        word_out(p);
        phase = LX_IDLE;
        return 1'b0;
      end
      LX_INT: begin
        if (is_digit(b)) begin
          t = 64'(int_mag) * 64'd10 + 64'(b - "0");
          int_mag = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
          return 1'b1;
        end
        if (b == CH_DOT) begin phase = LX_FRAC; return 1'b1; end
        if (b == CH_LOW_E || b == CH_UP_E) begin phase = LX_EXP; return 1'b1; end
        int_out(p);
        phase = LX_IDLE;
        return 1'b0;
      end
      LX_FRAC: begin
        if (is_digit(b)) return 1'b1;
        if (b == CH_LOW_E || b == CH_UP_E) begin phase = LX_EXP; return 1'b1; end
      end
      LX_EXP: begin
        if (b == CH_PLUS || b == CH_MINUS) begin phase = LX_EXPSIGN; return 1'b1; end
        if (is_digit(b)) begin phase = LX_EXPDIG; return 1'b1; end
      end
      LX_EXPSIGN, LX_EXPDIG: begin
        if (is_digit(b)) begin phase = LX_EXPDIG; return 1'b1; end
      end
      LX_STR: begin
        if (b == CH_BSLASH) phase = LX_ESC;
        else if (b == CH_SQUOTE) begin
          put(K_STR, OP_NONE, 8'd0, st + 16'd1, (p - st) - 16'd1, 32'd0, 16'd0, ERR_NONE);
          phase = LX_IDLE;
        end
        return 1'b1;
      end
      LX_ESC: begin
        phase = (b == CH_SQUOTE) ? LX_SKIP : LX_STR;
        return 1'b1;
      end
      LX_SKIP: begin
        phase = LX_STR;
        return 1'b1;
      end
      LX_QID: begin
        if (b == CH_DQUOTE) begin
          put(K_QNAME, OP_NONE, 8'd0, st + 16'd1, (p - st) - 16'd1, 32'd0, 16'd0, ERR_NONE);
          phase = LX_IDLE;
        end
        return 1'b1;
      end
      LX_DATE: begin
        word_len++;
        if (word_len >= 9) begin
          if (b == CH_RBRACK) begin
            put(K_DATE, OP_NONE, 8'd0, st + 16'd1, 16'd8, 32'd0, 16'd0, ERR_NONE);
            phase = LX_IDLE;
          end else begin
            put(K_ERR, OP_NONE, 8'd0, st, 16'd0, 32'd0, 16'd0, ERR_BAD_DATE);
            phase = LX_HALT;
          end
        end
        return 1'b1;
      end
      LX_HALT: return 1'b1;
      default: begin
        scan_idle(b, p);
        return 1'b1;
      end
    endcase
    // real number ends here
    put_tok(K_REAL, OP_NONE, p - st);
    phase = LX_IDLE;
    return 1'b0;
  endfunction

  function automatic void lexer_clear();
    phase      = LX_IDLE;
    held_valid = 1'b0;
    held_byte  = '0;
    byte_pos   = '0;
    param_cnt  = '0;
    word_len   = '0;
    word_buf   = '0;
    int_mag    = '0;
    int_neg    = 1'b0;
    tok_start  = '0;
  endfunction

  function automatic void close_query(logic [15:0] end_pos);
    if (held_valid) held_flush();
    else case (phase)
      LX_WORD: word_out(end_pos);
      LX_INT:  int_out(end_pos);
      LX_FRAC, LX_EXP, LX_EXPSIGN, LX_EXPDIG:
        put_tok(K_REAL, OP_NONE, end_pos - tok_start);
      LX_STR, LX_ESC, LX_SKIP:
        put(K_ERR, OP_NONE, 8'd0, tok_start, 16'd0, 32'd0, 16'd0, ERR_OPEN_STR);
      LX_QID:
        put(K_ERR, OP_NONE, 8'd0, tok_start, 16'd0, 32'd0, 16'd0, ERR_OPEN_QID);
      LX_DATE:
        put(K_ERR, OP_NONE, 8'd0, tok_start, 16'd0, 32'd0, 16'd0, ERR_BAD_DATE);
      default: ;
    endcase
    put(K_END, OP_NONE, 8'd0, end_pos, 16'd0, 32'd0, 16'd0, ERR_NONE);
    lexer_clear();
  endfunction

  function automatic void predict_tokens(in_req_t req);
    logic [15:0] p;
    p = byte_pos;
    run_tokens.delete();
    if (!scan(req.query_byte, p, req.end_of_query))
      void'(scan(req.query_byte, p, req.end_of_query));
    if (req.end_of_query) close_query(p + 16'd1);
    else byte_pos = p + 16'd1;
    if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last_of_run = 1'b1;
    foreach (run_tokens[i]) tokens_due.push_back(run_tokens[i]);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got, inout bit bad);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_res_t want;
    bit       bad;
    if (!rst_n) begin
      lexer_clear();
      tokens_due.delete();
    end else begin
      if (in_valid && !in_stall) predict_tokens(in_data);
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("token_kind: expected none, got %0h", out_data.token_kind);
          mismatch_count++;
        end else begin
          want = tokens_due.pop_front();
          bad  = 1'b0;
          check_field("token_kind", want.token_kind, out_data.token_kind, bad);
          check_field("operator_code", want.operator_code, out_data.operator_code, bad);
          check_field("char_code", want.char_code, out_data.char_code, bad);
          check_field("token_start", want.token_start, out_data.token_start, bad);
          check_field("token_length", want.token_length, out_data.token_length, bad);
          check_field("int_value", want.int_value, out_data.int_value, bad);
          check_field("param_index", want.param_index, out_data.param_index, bad);
          check_field("error_code", want.error_code, out_data.error_code, bad);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run, bad);
          if (bad) mismatch_count++;
        end
      end
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

// File: bench/tb_sql_query_tokenizer.sv
`timescale 1ns / 100ps
module tb_sql_query_tokenizer;
  import sqt_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;
  int       mismatch_count, tokens_waiting;
  int       send_gap_pct, recv_stall_pct, bytes_sent, quiet;
  logic [7:0] query_text[$];

  always #4 clk = ~clk;

  sql_query_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sqt_token_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .mismatch_count(mismatch_count), .tokens_waiting(tokens_waiting)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) query_text.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) query_text.push_back(8'("0" + $urandom_range(9)));
  endtask

  task automatic add_fragment();
    int         i, n;
    logic [7:0] ch;
    case ($urandom_range(12))
      0: begin
        if ($urandom_range(1)) add_text("-");
        add_digits($urandom_range(1, 11));
      end
      1: begin
        if ($urandom_range(1)) add_digits($urandom_range(1, 3));
        add_text(".");
        add_digits($urandom_range(1, 2));
        if ($urandom_range(1)) begin
          add_text($urandom_range(1) ? "e" : "E");
          case ($urandom_range(2))
            0: add_text("+");
            1: add_text("-");
            default: ;
          endcase
          add_digits($urandom_range(0, 2));
        end
      end
      2: begin
        add_text("'");
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(3))
            0: add_text("\\'");
            1: add_text("\\'x");
            2: add_text("\\\\");
            default: query_text.push_back(8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(9) != 0) add_text("'");
      end
      3: add_text($urandom_range(1) ? "\"Col x\"" : "\"\"");
      4: begin
        add_text("[");
        n = $urandom_range(3) == 0 ? $urandom_range(0, 8) : 8;
        add_digits(n);
        if (n == 8) add_text($urandom_range(3) == 0 ? "x" : "]");
      end
      5: add_text(":");
      6: add_text($urandom_range(1) ? "?" : "??");
      7: begin
        case ($urandom_range(13))
          0: add_text("<=");  1: add_text("<>");  2: add_text("!=");
          3: add_text("==");  4: add_text(">=");  5: add_text("<");
          6: add_text(">");   7: add_text("=");   8: add_text("!");
          9: add_text("+");   10: add_text("-");  11: add_text("*");
          12: add_text("/");  default: add_text(".");
        endcase
      end
      8, 9: begin
        i = $urandom_range(KW_COUNT - 1);
        for (int j = int'(KW_TABLE[i].len) - 1; j >= 0; j--) begin
          ch = KW_TABLE[i].txt[8*j +: 8];
          if ($urandom_range(1)) ch = ch & 8'hDF;
          query_text.push_back(ch);
        end
        if (KW_TABLE[i].fn && $urandom_range(3) != 0) add_text("(");
      end
      10: begin
        add_text($urandom_range(1) ? "_" : "Q");
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(2))
            0: query_text.push_back(8'($urandom_range(97, 122)));
            1: query_text.push_back(8'($urandom_range(48, 57)));
            default: add_text("_");
          endcase
        end
      end
      default: query_text.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_byte(logic [7:0] b, logic eoq);
    in_valid <= 1'b1;
    in_data  <= in_req_t'{query_byte: b, end_of_query: eoq};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_query();
    foreach (query_text[i]) send_byte(query_text[i], i == query_text.size() - 1);
    query_text.delete();
  endtask

  initial begin
    bytes_sent = 0;
    send_gap_pct = 24;
    recv_stall_pct = 81;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_text("-2147483649"); send_query();
    add_text("4294967296"); send_query();
    add_text("a>=!"); send_query();
    add_text("max("); send_query();
    query_text.push_back(8'hFF); query_text.push_back(8'h00); send_query();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_gap_pct = 81;
        recv_stall_pct = 24;
      end else if (ph == 2) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      while (bytes_sent < 30 * (ph + 1) + 10) begin
        repeat ($urandom_range(1, 6)) begin
          add_fragment();
          case ($urandom_range(3))
            0: ;
            1: query_text.push_back(8'h09);
            default: add_text(" ");
          endcase
        end
        send_query();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (tokens_waiting == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && tokens_waiting == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
